// ===== hw/rtl/sid_pkg.sv =====
// ----------------------------------------------------------------------------
// sid_pkg
// Shared types and constants for the signed integer divider.
// ----------------------------------------------------------------------------
`default_nettype none

package sid_pkg;

  localparam int DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2
  } sid_status_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] numerator;
    logic signed [DATA_WIDTH-1:0] denominator;
  } sid_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] quotient;
    sid_status_t                  status;
  } sid_rsp_t;

  typedef struct packed {
    logic                  valid;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] dq;
    logic [DATA_WIDTH-1:0] dmag;
    logic                  negate;
    sid_status_t           status;
  } sid_work_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sid_front.sv =====
// ----------------------------------------------------------------------------
// sid_front
// Entry stage: takes operand magnitudes, result sign and special cases.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              advance,
  input  wire logic              request_valid,
  input  wire sid_pkg::sid_req_t request,
  output sid_pkg::sid_work_t     work
);
  import sid_pkg::*;

  localparam logic [DATA_WIDTH-1:0] SignBit = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] AllOnes = {DATA_WIDTH{1'b1}};

  logic [DATA_WIDTH-1:0] n;
  logic [DATA_WIDTH-1:0] d;
  sid_work_t             work_next;

  always_comb begin
    n = request.numerator;
    d = request.denominator;
    work_next.valid  = request_valid;
    work_next.rem    = '0;
    work_next.dq     = n[DATA_WIDTH-1] ? (~n + 1'b1) : n;
    work_next.dmag   = d[DATA_WIDTH-1] ? (~d + 1'b1) : d;
    work_next.negate = n[DATA_WIDTH-1] ^ d[DATA_WIDTH-1];
    priority if (d == '0) begin
      work_next.status = ST_DIV0;
    end else if (n == SignBit && d == AllOnes) begin
      work_next.status = ST_SAT;
    end else begin
      work_next.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      work.valid <= 1'b0;
    end else if (advance) begin
      work <= work_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sid_cell.sv =====
// ----------------------------------------------------------------------------
// sid_cell
// One restoring division step: shift in a dividend bit, trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire sid_pkg::sid_work_t up,
  output sid_pkg::sid_work_t      down
);
  import sid_pkg::*;

  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  sid_work_t             down_next;

  always_comb begin
    shifted   = {up.rem[DATA_WIDTH-2:0], up.dq[DATA_WIDTH-1]};
    diff      = {1'b0, shifted} - {1'b0, up.dmag};
    down_next = up;
    if (diff[DATA_WIDTH]) begin
      down_next.rem = shifted;
      down_next.dq  = {up.dq[DATA_WIDTH-2:0], 1'b0};
    end else begin
      down_next.rem = diff[DATA_WIDTH-1:0];
      down_next.dq  = {up.dq[DATA_WIDTH-2:0], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down.valid <= 1'b0;
    end else if (advance) begin
      down <= down_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sid_back.sv =====
// ----------------------------------------------------------------------------
// sid_back
// Output stage: apply sign, override special cases, hold the result.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               advance,
  input  wire sid_pkg::sid_work_t work,
  output logic                    result_valid,
  output sid_pkg::sid_rsp_t       result
);
  import sid_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  sid_rsp_t result_next;

  always_comb begin
    result_next.status = work.status;
    unique case (work.status)
      ST_OK:   result_next.quotient = work.negate ? (~work.dq + 1'b1) : work.dq;
      ST_SAT:  result_next.quotient = MaxPos;
      ST_DIV0: result_next.quotient = '0;
      default: result_next.quotient = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= work.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) result <= result_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/signed_integer_divider.sv =====
// ----------------------------------------------------------------------------
// signed_integer_divider
// Signed 32-bit divider, quotient truncated toward zero, no remainder.
//
// A request carries numerator and denominator; it is taken at a clock edge
// where request_valid is high and request_stall is low. Each request yields
// one result (quotient, status) on the result channel, taken where
// result_valid is high and result_stall is low.
// Status: ok, saturated (most negative over minus one gives the largest
// positive value) or divide by zero (quotient zero).
// The pipeline has an entry stage for magnitudes and flags, a row of
// DATA_WIDTH division cells that each produce one quotient bit, and an
// output stage that applies the sign.
// Requests flow through the cell row one behind another, so a new request
// may enter every cycle while the result channel keeps up.
// While a result waits under result_stall, the whole row holds and
// request_stall is raised. Synchronous reset empties every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              request_valid,
  output logic                   request_stall,
  input  wire sid_pkg::sid_req_t request,
  output logic                   result_valid,
  input  wire logic              result_stall,
  output sid_pkg::sid_rsp_t      result
);
  import sid_pkg::*;

  logic      advance;
  sid_work_t stage [DATA_WIDTH+1];

  assign advance       = !(result_valid && result_stall);
  assign request_stall = !advance;

  sid_front u_front (
    .clk,
    .rst,
    .advance,
    .request_valid,
    .request,
    .work (stage[0])
  );

  for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
    sid_cell u_cell (
      .clk,
      .rst,
      .advance,
      .up   (stage[i]),
      .down (stage[i+1])
    );
  end

  sid_back u_back (
    .clk,
    .rst,
    .advance,
    .work (stage[DATA_WIDTH]),
    .result_valid,
    .result
  );

endmodule

`default_nettype wire

// ===== hw/rtl/sid_checker.sv =====
// ----------------------------------------------------------------------------
// sid_checker
// Port-level checks for the signed integer divider, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module sid_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              request_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire sid_pkg::sid_rsp_t result
);
  import sid_pkg::*;

  localparam logic [DATA_WIDTH-1:0] MaxPos = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    request_stall == (result_valid && result_stall))
    else $error("request stall does not follow result stall");

  a_div0: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_DIV0 |-> result.quotient == '0)
    else $error("divide by zero with nonzero quotient");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_SAT |-> result.quotient == MaxPos)
    else $error("saturated result not at largest positive value");

  a_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

endmodule

bind signed_integer_divider sid_checker u_sid_checker (.*);

`default_nettype wire

// ===== sim/signed_integer_divider_test.sv =====
// ----------------------------------------------------------------------------
// signed_integer_divider_test
// Self-checking bench for the signed integer divider.
//
// A queue of requests (directed corner cases, then random operands with a
// bias toward signs, powers of two, small values, zero and the overflow pair)
// is fed through a clocked driver. A clocked monitor computes the expected
// quotient and status for every accepted request and compares each accepted
// result against the oldest expectation. Sender gaps and receiver stalls
// change by phase; one long receiver hold-off backs up the pipeline, and one
// sender pause lets the pipeline drain completely.
// ----------------------------------------------------------------------------
module signed_integer_divider_test;

  import sid_pkg::*;

  localparam int                    W             = DATA_WIDTH;
  localparam logic [DATA_WIDTH-1:0] MOST_NEG      = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MOST_POS      = ~MOST_NEG;
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE     = '1;
  localparam int                    RANDOM_ITEMS  = 600;
  localparam int                    PHASE_ITEMS   = 90;
  localparam int                    HOLD_AT       = 150;
  localparam int                    HOLD_CYCLES   = 300;
  localparam int                    PAUSE_AT      = 450;
  localparam int                    TAIL_CYCLES   = 2 * (DATA_WIDTH + 2);
  localparam int                    CYCLE_LIMIT   = 400000;

  logic     clk           = 1'b0;
  logic     rst           = 1'b1;
  logic     request_valid = 1'b0;
  logic     request_stall;
  sid_req_t request       = '0;
  logic     result_valid;
  logic     result_stall  = 1'b0;
  sid_rsp_t result;

  sid_req_t pending_requests[$];
  sid_rsp_t expected_quotients[$];
  sid_rsp_t expected_head;
  int       requests_sent = 0;
  int       results_seen  = 0;
  int       next_sent;
  int       hold_left     = 0;
  logic     hold_done     = 1'b0;
  int       mismatches    = 0;

  signed_integer_divider dut (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic sid_rsp_t predict_quotient(sid_req_t req);
    logic [W-1:0] n;
    logic [W-1:0] d;
    logic [W-1:0] nmag;
    logic [W-1:0] dmag;
    logic [W-1:0] q;
    sid_rsp_t     r;
    n = req.numerator;
    d = req.denominator;
    if (d == '0) begin
      r.quotient = '0;
      r.status   = ST_DIV0;
    end else if (n == MOST_NEG && d == MINUS_ONE) begin
      r.quotient = MOST_POS;
      r.status   = ST_SAT;
    end else begin
      nmag = n[W-1] ? -n : n;
      dmag = d[W-1] ? -d : d;
      q    = nmag / dmag;
      if (n[W-1] ^ d[W-1]) q = -q;
      r.quotient = q;
      r.status   = ST_OK;
    end
    return r;
  endfunction

  function automatic logic [W-1:0] random_operand();
    logic [W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 9: v = $urandom;
      4, 5: v = $urandom_range(0, 32) - 16;
      6: begin
        case ($urandom_range(0, 4))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = '0;
          3: v = 1;
          default: v = MINUS_ONE;
        endcase
      end
      7: begin
        v = 1;
        v = v << $urandom_range(0, W - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
      default: begin
        v = $urandom;
        v = v >> $urandom_range(0, W - 1);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic void add_request(logic [W-1:0] n, logic [W-1:0] d);
    sid_req_t req;
    req.numerator   = n;
    req.denominator = d;
    pending_requests = {pending_requests, req};
  endfunction

  function automatic int sender_gap_pct(int phase);
    case (phase)
      1: return 45;
      3: return 19;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct(int phase);
    case (phase)
      2: return 45;
      3: return 19;
      default: return 0;
    endcase
  endfunction

  // Driver: present the next request once the previous one is taken.
  always @(posedge clk) begin
    if (rst) begin
      request_valid <= 1'b0;
    end else if (!request_valid || !request_stall) begin
      next_sent = requests_sent + (request_valid ? 1 : 0);
      requests_sent <= next_sent;
      if (pending_requests.size() == 0) begin
        request_valid <= 1'b0;
      end else if (next_sent == PAUSE_AT && results_seen != next_sent) begin
        request_valid <= 1'b0;
      end else if (hold_left == 0 &&
                   $urandom_range(0, 99) < sender_gap_pct((next_sent / PHASE_ITEMS) % 4)) begin
        request_valid <= 1'b0;
      end else begin
        request       <= pending_requests.pop_front();
        request_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stalls by phase, plus one long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES;
      result_stall <= 1'b1;
    end else begin
      result_stall <=
        $urandom_range(0, 99) < receiver_stall_pct((requests_sent / PHASE_ITEMS) % 4);
    end
  end

  // Monitor: predict on every accepted request, check every accepted result.
  always @(posedge clk) begin
    if (!rst) begin
      if (request_valid && !request_stall) begin
        expected_quotients = {expected_quotients, predict_quotient(request)};
      end
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (expected_quotients.size() == 0) begin
          $error("result with no request outstanding: quotient %0d, status %0d",
                 result.quotient, result.status);
          mismatches++;
        end else begin
          expected_head = expected_quotients.pop_front();
          if (result.quotient !== expected_head.quotient) begin
            $error("quotient: expected %0d, actual %0d",
                   expected_head.quotient, result.quotient);
            mismatches++;
          end
          if (result.status !== expected_head.status) begin
            $error("status: expected %0d, actual %0d",
                   expected_head.status, result.status);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin
    int total;
    int cycles;
    logic [W-1:0] n;
    logic [W-1:0] d;

    add_request('0, 5);
    add_request('0, -5);
    add_request('0, MOST_NEG);
    add_request(5, '0);
    add_request(-5, '0);
    add_request('0, '0);
    add_request(MOST_NEG, '0);
    add_request(MOST_POS, '0);
    add_request(MOST_NEG, MINUS_ONE);
    add_request(MOST_NEG, 1);
    add_request(MOST_NEG, MOST_NEG);
    add_request(MOST_NEG, MOST_POS);
    add_request(MOST_NEG, 2);
    add_request(MOST_POS, MOST_NEG);
    add_request(MOST_POS, MOST_POS);
    add_request(MOST_POS, 1);
    add_request(MOST_POS, MINUS_ONE);
    add_request(1, MOST_POS);
    add_request(MINUS_ONE, MOST_NEG);
    add_request(7, 2);
    add_request(-7, 2);
    add_request(7, -2);
    add_request(-7, -2);
    add_request(3, 7);
    add_request(100, -100);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        n = MOST_NEG;
        d = MINUS_ONE;
      end else begin
        n = random_operand();
        d = random_operand();
      end
      add_request(n, d);
    end
    total = pending_requests.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    cycles = 0;
    while (!(requests_sent == total && results_seen == total) && cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end

    if (cycles >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (mismatches == 0 && expected_quotients.size() == 0) begin
        $display("end of test: clean");
      end else begin
        $display("end of test: mismatches");
      end
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/sid_pkg.sv
hw/rtl/sid_front.sv
hw/rtl/sid_cell.sv
hw/rtl/sid_back.sv
hw/rtl/signed_integer_divider.sv
hw/rtl/sid_checker.sv
sim/signed_integer_divider_test.sv
